// ===== hdl/lzwc_pkg.sv =====
// Shared types and constants for the LZW compressor.
// No dependencies.
`timescale 1ns / 1ps

package lzwc_pkg;

    localparam int MAX_BITS = 12;
    localparam int CODE_W   = 12;
    localparam int KEY_W    = 20;
    localparam int NF_W     = 13;

    localparam logic [NF_W-1:0]   FIRST_FREE = 13'd257;
    localparam logic [NF_W-1:0]   CODE_LIMIT = 13'd4096;
    localparam logic [NF_W-1:0]   MAX_CODE9  = 13'd511;
    localparam logic [CODE_W-1:0] CLEAR_CODE = 12'd256;
    localparam logic [3:0]        MIN_WIDTH  = 4'd9;
    localparam logic [3:0]        TOP_WIDTH  = 4'd12;
    localparam logic [5:0]        MAX_OUT    = 6'd48;
    localparam logic [19:0]       INTERVAL_RST = 20'd10000;
    localparam logic [31:0]       RATIO_MAX  = 32'h7fffffff;
    localparam logic [31:0]       SMALL_IN   = 32'h007fffff;

    localparam logic CFG_INTERVAL = 1'b0;
    localparam logic CFG_FORCE    = 1'b1;

    typedef logic [MAX_BITS-1:0][7:0] t_pack;

    typedef struct packed {
        logic              valid;
        logic [KEY_W-1:0]  key;
        logic [CODE_W-1:0] code;
    } t_entry;

endpackage

// ===== hdl/lzw_compressor_variable_width.sv =====
// LZW compressor top level: hashed dictionary in one synchronous RAM,
// code packer, ratio-check divider and output staging. Uses lzwc_pkg.
`timescale 1ns / 1ps

// Channel   Dir  Handshake                Payload
// in        in   i_in_valid / o_in_ready  i_data_byte, i_end_of_stream
// out       out  o_out_valid / i_out_ready o_out_byte, o_last_of_run
// cfg       in   i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// One byte at a time: each hash probe is a read of the RAM's one read port,
// which is registered; a miss adds packing and the table update, and each
// buffer sent is moved out byte by byte.
// A ratio check adds a 32-step restoring divide (skipped for a zero divisor);
// a table clear adds a sweep over every entry of the RAM. After reset the
// same sweep runs before the first byte is taken. A stalled output holds the
// sequencer; the last byte of a run is held back one transfer to mark it.

module lzw_compressor_variable_width #(
    parameter int TABLE_SIZE = 5003
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_end_of_stream,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_out_byte,
    output logic        o_last_of_run,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [19:0] i_cfg_data
);

    localparam int SW = $clog2(TABLE_SIZE);
    localparam int PW = $clog2(TABLE_SIZE + 1);
    localparam logic [SW-1:0] TS_S   = SW'(TABLE_SIZE);
    localparam logic [SW:0]   TS_X   = (SW+1)'(TABLE_SIZE);
    localparam logic [SW-1:0] LAST_S = SW'(TABLE_SIZE - 1);
    localparam logic [PW-1:0] LAST_P = PW'(TABLE_SIZE - 1);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_PISSUE = 4'd1;
    localparam logic [3:0] S_PCHK   = 4'd2;
    localparam logic [3:0] S_MPOST  = 4'd3;
    localparam logic [3:0] S_RINIT  = 4'd4;
    localparam logic [3:0] S_RDIV   = 4'd5;
    localparam logic [3:0] S_RCMP   = 4'd6;
    localparam logic [3:0] S_EOS    = 4'd7;
    localparam logic [3:0] S_FLUSH  = 4'd8;
    localparam logic [3:0] S_FIN    = 4'd9;
    localparam logic [3:0] S_EPACK  = 4'd10;
    localparam logic [3:0] S_ECHK   = 4'd11;
    localparam logic [3:0] S_SEND   = 4'd12;
    localparam logic [3:0] S_CLR    = 4'd13;

    lzwc_pkg::t_entry r_table [TABLE_SIZE];
    lzwc_pkg::t_entry r_rd;

    logic [3:0]  r_state, n_state, r_ret, n_ret, r_sret, n_sret, r_cret, n_cret;
    logic [7:0]  r_b, n_b;
    logic        r_eos, n_eos, r_seed, n_seed, r_cp, n_cp, r_force, n_force;
    logic [11:0] r_prefix, n_prefix, r_code, n_code;
    logic [12:0] r_nf, n_nf, r_max, n_max;
    logic [3:0]  r_cw, n_cw, r_sn, n_sn, r_si, n_si;
    lzwc_pkg::t_pack r_pb, n_pb, w_packed;
    logic [6:0]  r_bp, n_bp;
    logic [31:0] r_in, n_in, r_ocnt, n_ocnt, r_best, n_best, r_chk, n_chk;
    logic [19:0] r_interval, n_interval, r_key, n_key;
    logic [SW-1:0] r_slot, n_slot, r_step, n_step, r_clr, n_clr;
    logic [PW-1:0] r_probe, n_probe;
    logic        r_exh, n_exh, r_empty, n_empty;
    logic [5:0]  r_nres, n_nres;
    logic        r_hold_v, n_hold_v, r_out_valid, n_out_valid, r_out_last, n_out_last;
    logic [7:0]  r_hold, n_hold, r_out_byte, n_out_byte;
    logic [31:0] r_dq, n_dq, r_dd, n_dd;
    logic [32:0] r_rem, n_rem;
    logic [4:0]  r_dcnt, n_dcnt;

    logic          w_we;
    logic [SW-1:0] w_wa;
    lzwc_pkg::t_entry w_wd;

    // code packer
    always_comb begin
        logic [2:0]  off;
        logic [3:0]  idx, idx2, first, rem, rem2;
        logic [11:0] c1, c2;
        logic [7:0]  lo, keep;
        off   = r_bp[2:0];
        idx   = r_bp[6:3];
        first = 4'd8 - {1'b0, off};
        lo    = 8'({8'd0, r_code} << off);
        keep  = 8'((9'd1 << off) - 9'd1);
        c1    = r_code >> first;
        rem   = (r_cw > first) ? r_cw - first : 4'd0;
        w_packed = r_pb;
        if (idx < 4'(lzwc_pkg::MAX_BITS)) begin
            w_packed[idx] = (r_pb[idx] & keep) | lo;
        end
        if (rem >= 4'd8) begin
            if (idx + 4'd1 < 4'(lzwc_pkg::MAX_BITS)) begin
                w_packed[idx + 4'd1] = c1[7:0];
            end
            idx2 = idx + 4'd2;
            c2   = c1 >> 8;
            rem2 = rem - 4'd8;
        end else begin
            idx2 = idx + 4'd1;
            c2   = c1;
            rem2 = rem;
        end
        if (rem2 != 4'd0 && idx2 < 4'(lzwc_pkg::MAX_BITS)) begin
            w_packed[idx2] = c2[7:0];
        end
    end

    always_comb begin
        logic          can_push, hit;
        logic [6:0]    bp_sum;
        logic [11:0]   h;
        logic [SW-1:0] s0;
        logic [32:0]   rem_sh;
        logic [31:0]   dvd, dvs;
        logic [3:0]    cw_up, nfl;
        can_push = !r_out_valid || i_out_ready;
        hit      = 1'b0;
        bp_sum   = 7'd0;
        h        = 12'd0;
        s0       = '0;
        rem_sh   = 33'd0;
        dvd      = 32'd0;
        dvs      = 32'd0;
        cw_up    = 4'd0;
        nfl      = 4'd0;

        n_state = r_state;  n_ret = r_ret;    n_sret = r_sret;  n_cret = r_cret;
        n_b = r_b;          n_eos = r_eos;    n_seed = r_seed;  n_cp = r_cp;
        n_force = r_force;  n_prefix = r_prefix; n_code = r_code;
        n_nf = r_nf;        n_max = r_max;    n_cw = r_cw;      n_sn = r_sn;
        n_si = r_si;        n_pb = r_pb;      n_bp = r_bp;      n_in = r_in;
        n_ocnt = r_ocnt;    n_best = r_best;  n_chk = r_chk;
        n_interval = r_interval; n_key = r_key; n_slot = r_slot; n_step = r_step;
        n_clr = r_clr;      n_probe = r_probe; n_exh = r_exh;   n_empty = r_empty;
        n_nres = r_nres;    n_hold_v = r_hold_v; n_hold = r_hold;
        n_out_valid = r_out_valid & ~i_out_ready;
        n_out_byte = r_out_byte; n_out_last = r_out_last;
        n_dq = r_dq;        n_dd = r_dd;      n_rem = r_rem;    n_dcnt = r_dcnt;
        w_we = 1'b0;
        w_wa = r_slot;
        w_wd = '0;

        if (i_cfg_valid) begin
            if (i_cfg_index == lzwc_pkg::CFG_INTERVAL) begin
                n_interval = i_cfg_data;
            end else begin
                n_force = i_cfg_data[0];
            end
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_b   = i_data_byte;
                    n_eos = i_end_of_stream;
                    if (r_seed) begin
                        n_prefix = {4'd0, i_data_byte};
                        n_seed   = 1'b0;
                        n_state  = S_EOS;
                    end else begin
                        h       = {i_data_byte, 4'd0} ^ r_prefix;
                        s0      = SW'(h);
                        n_in    = r_in + 32'd1;
                        n_key   = {i_data_byte, r_prefix};
                        n_slot  = s0;
                        n_step  = (s0 == '0) ? SW'(1) : TS_S - s0;
                        n_probe = '0;
                        n_exh   = 1'b0;
                        n_state = S_PISSUE;
                    end
                end
            end
            S_PISSUE: n_state = S_PCHK;
            S_PCHK: begin
                hit = r_rd.valid && (r_rd.key == r_key) && !r_exh;
                if (hit) begin
                    n_prefix = r_rd.code;
                    n_state  = S_EOS;
                end else if (!r_rd.valid || r_exh) begin
                    n_empty = !r_rd.valid;
                    n_code  = r_prefix;
                    n_ret   = S_MPOST;
                    n_state = S_EPACK;
                end else begin
                    n_slot  = (r_slot >= r_step) ? r_slot - r_step
                            : SW'(({1'b0, r_slot} + TS_X) - {1'b0, r_step});
                    n_probe = r_probe + PW'(1);
                    n_exh   = (r_probe == LAST_P);
                    n_state = S_PISSUE;
                end
            end
            S_MPOST: begin
                n_prefix = {4'd0, r_b};
                n_state  = S_EOS;
                if (r_nf < lzwc_pkg::CODE_LIMIT) begin
                    if (r_empty) begin
                        w_we  = 1'b1;
                        w_wd  = '{valid: 1'b1, key: r_key, code: r_nf[11:0]};
                        n_nf  = r_nf + 13'd1;
                    end
                end else if (r_in >= r_chk || r_force) begin
                    n_state = S_RINIT;
                end
            end
            S_RINIT: begin
                n_chk = r_in + {12'd0, r_interval};
                if (r_in <= lzwc_pkg::SMALL_IN) begin
                    dvd = {r_in[23:0], 8'd0};
                    dvs = r_ocnt;
                end else begin
                    dvd = r_in;
                    dvs = {8'd0, r_ocnt[31:8]};
                end
                if (dvs == 32'd0) begin
                    n_dq    = lzwc_pkg::RATIO_MAX;
                    n_state = S_RCMP;
                end else begin
                    n_dq    = dvd;
                    n_dd    = dvs;
                    n_rem   = 33'd0;
                    n_dcnt  = 5'd0;
                    n_state = S_RDIV;
                end
            end
            S_RDIV: begin
                rem_sh = {r_rem[31:0], r_dq[31]};
                if (rem_sh >= {1'b0, r_dd}) begin
                    n_rem = rem_sh - {1'b0, r_dd};
                    n_dq  = {r_dq[30:0], 1'b1};
                end else begin
                    n_rem = rem_sh;
                    n_dq  = {r_dq[30:0], 1'b0};
                end
                n_dcnt = r_dcnt + 5'd1;
                if (r_dcnt == 5'd31) begin
                    n_state = S_RCMP;
                end
            end
            S_RCMP: begin
                if (r_dq > r_best) begin
                    n_best  = r_dq;
                    n_state = S_EOS;
                end else begin
                    n_best  = 32'd0;
                    n_nf    = lzwc_pkg::FIRST_FREE;
                    n_cp    = 1'b1;
                    n_code  = lzwc_pkg::CLEAR_CODE;
                    n_clr   = '0;
                    n_cret  = S_EOS;
                    n_ret   = S_CLR;
                    n_state = S_EPACK;
                end
            end
            S_EOS: begin
                if (r_eos) begin
                    n_code  = r_prefix;
                    n_ret   = S_FLUSH;
                    n_state = S_EPACK;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_FLUSH: begin
                nfl    = 4'((8'({1'b0, r_bp}) + 8'd7) >> 3);
                n_ocnt = r_ocnt + {28'd0, nfl};
                n_bp   = 7'd0;
                if (r_bp != 7'd0) begin
                    n_sn    = nfl;
                    n_si    = 4'd0;
                    n_sret  = S_FIN;
                    n_state = S_SEND;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (!r_hold_v) begin
                    n_nres  = 6'd0;
                    n_state = S_IDLE;
                end else if (can_push) begin
                    n_out_valid = 1'b1;
                    n_out_byte  = r_hold;
                    n_out_last  = 1'b1;
                    n_hold_v    = 1'b0;
                    n_nres      = 6'd0;
                    n_state     = S_IDLE;
                end
            end
            S_EPACK: begin
                n_pb   = w_packed;
                bp_sum = r_bp + {3'd0, r_cw};
                if (bp_sum == {r_cw, 3'd0}) begin
                    n_bp    = 7'd0;
                    n_ocnt  = r_ocnt + {28'd0, r_cw};
                    n_sn    = r_cw;
                    n_si    = 4'd0;
                    n_sret  = S_ECHK;
                    n_state = S_SEND;
                end else begin
                    n_bp    = bp_sum;
                    n_state = S_ECHK;
                end
            end
            S_ECHK: begin
                n_state = r_ret;
                if (r_nf > r_max || r_cp) begin
                    if (r_bp != 7'd0) begin
                        n_ocnt  = r_ocnt + {28'd0, r_cw};
                        n_sn    = r_cw;
                        n_si    = 4'd0;
                        n_sret  = r_ret;
                        n_state = S_SEND;
                    end
                    n_bp = 7'd0;
                    if (r_cp) begin
                        n_cw  = lzwc_pkg::MIN_WIDTH;
                        n_max = lzwc_pkg::MAX_CODE9;
                        n_cp  = 1'b0;
                    end else begin
                        cw_up = (r_cw < lzwc_pkg::TOP_WIDTH) ? r_cw + 4'd1 : r_cw;
                        n_cw  = cw_up;
                        n_max = (cw_up == lzwc_pkg::TOP_WIDTH) ? lzwc_pkg::CODE_LIMIT
                              : 13'((14'd1 << cw_up) - 14'd1);
                    end
                end
            end
            S_SEND: begin
                if (r_si == r_sn) begin
                    n_state = r_sret;
                end else if (r_nres >= lzwc_pkg::MAX_OUT) begin
                    n_si = r_si + 4'd1;
                end else if (!r_hold_v) begin
                    n_hold   = r_pb[r_si];
                    n_hold_v = 1'b1;
                    n_si     = r_si + 4'd1;
                    n_nres   = r_nres + 6'd1;
                end else if (can_push) begin
                    n_out_valid = 1'b1;
                    n_out_byte  = r_hold;
                    n_out_last  = 1'b0;
                    n_hold      = r_pb[r_si];
                    n_si        = r_si + 4'd1;
                    n_nres      = r_nres + 6'd1;
                end
            end
            S_CLR: begin
                w_we  = 1'b1;
                w_wa  = r_clr;
                w_wd  = '0;
                n_clr = r_clr + SW'(1);
                if (r_clr == LAST_S) begin
                    n_state = r_cret;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_table[w_wa] <= w_wd;
        end
        r_rd <= r_table[r_slot];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;  r_ret <= S_IDLE;  r_sret <= S_IDLE;  r_cret <= S_IDLE;
            r_b <= 8'd0;       r_eos <= 1'b0;    r_seed <= 1'b1;    r_cp <= 1'b0;
            r_force <= 1'b0;   r_prefix <= 12'd0; r_code <= 12'd0;
            r_nf <= lzwc_pkg::FIRST_FREE;        r_max <= lzwc_pkg::MAX_CODE9;
            r_cw <= lzwc_pkg::MIN_WIDTH;         r_sn <= 4'd0;      r_si <= 4'd0;
            r_pb <= '0;        r_bp <= 7'd0;     r_in <= 32'd1;     r_ocnt <= 32'd0;
            r_best <= 32'd0;   r_chk <= {12'd0, lzwc_pkg::INTERVAL_RST};
            r_interval <= lzwc_pkg::INTERVAL_RST; r_key <= 20'd0;
            r_slot <= '0;      r_step <= '0;     r_clr <= '0;       r_probe <= '0;
            r_exh <= 1'b0;     r_empty <= 1'b0;  r_nres <= 6'd0;
            r_hold_v <= 1'b0;  r_hold <= 8'd0;   r_out_valid <= 1'b0;
            r_out_byte <= 8'd0; r_out_last <= 1'b0;
            r_dq <= 32'd0;     r_dd <= 32'd0;    r_rem <= 33'd0;    r_dcnt <= 5'd0;
        end else begin
            r_state <= n_state;  r_ret <= n_ret;   r_sret <= n_sret;  r_cret <= n_cret;
            r_b <= n_b;          r_eos <= n_eos;   r_seed <= n_seed;  r_cp <= n_cp;
            r_force <= n_force;  r_prefix <= n_prefix; r_code <= n_code;
            r_nf <= n_nf;        r_max <= n_max;   r_cw <= n_cw;      r_sn <= n_sn;
            r_si <= n_si;        r_pb <= n_pb;     r_bp <= n_bp;      r_in <= n_in;
            r_ocnt <= n_ocnt;    r_best <= n_best; r_chk <= n_chk;
            r_interval <= n_interval; r_key <= n_key;
            r_slot <= n_slot;    r_step <= n_step; r_clr <= n_clr;    r_probe <= n_probe;
            r_exh <= n_exh;      r_empty <= n_empty; r_nres <= n_nres;
            r_hold_v <= n_hold_v; r_hold <= n_hold; r_out_valid <= n_out_valid;
            r_out_byte <= n_out_byte; r_out_last <= n_out_last;
            r_dq <= n_dq;        r_dd <= n_dd;     r_rem <= n_rem;    r_dcnt <= n_dcnt;
        end
    end

    assign o_in_ready    = (r_state == S_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign o_out_valid   = r_out_valid;
    assign o_out_byte    = r_out_byte;
    assign o_last_of_run = r_out_last;

    a_idle_no_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !r_hold_v)
        else $error("held byte left over at idle");
    a_width_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cw >= lzwc_pkg::MIN_WIDTH) && (r_cw <= lzwc_pkg::TOP_WIDTH))
        else $error("code width out of range");
    a_nf_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_nf <= lzwc_pkg::CODE_LIMIT)
        else $error("next free code past limit");
    a_bp_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> (r_bp < {r_cw, 3'd0}))
        else $error("bit position past buffer");

endmodule
